[sv/bums_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bums_pkg - shared types for the bottom-up merge sorter
// Word widths and the control bundle that drives the sorting cell chain.
// ----------------------------------------------------------------------------
package bums_pkg;

	// Width of a key on the stream ports
	localparam int KEY_W = 16;

	// Per-cycle command broadcast to every cell of the chain
	typedef struct packed {
		logic ins;    // place the new key, push larger keys one cell right
		logic shift;  // move every key one cell left toward the output
	} bums_ctl_t;

endpackage
`default_nettype wire

[sv/bums_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bums_cell - one slot of the sorting chain
// Holds one key and its valid bit. On insert it keeps its key, takes the new
// key, or takes its left neighbor's key; on shift it takes the right neighbor's.
// ----------------------------------------------------------------------------
module bums_cell #(
	parameter int KW = 16
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire bums_pkg::bums_ctl_t  ctl,
	input  wire  [KW-1:0]             new_key,
	input  wire                       left_keep,
	input  wire  [KW-1:0]             left_key,
	input  wire                       left_valid,
	input  wire  [KW-1:0]             right_key,
	input  wire                       right_valid,
	output logic                      keep,
	output logic [KW-1:0]             key,
	output logic                      valid
);

	logic [KW-1:0] key_q;
	logic          valid_q;

	// a cell whose key is not above the new key stays put
	assign keep  = valid_q && (key_q <= new_key);
	assign key   = key_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= right_valid;
		end else if (ctl.ins && !keep) begin
			valid_q <= left_keep ? 1'b1 : left_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			key_q <= right_key;
		end else if (ctl.ins && !keep) begin
			key_q <= left_keep ? new_key : left_key;
		end
	end

endmodule
`default_nettype wire

[sv/bottom_up_merge_sorter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bottom_up_merge_sorter - streaming key sorter
// Loads a list of keys, then streams it back in ascending order.
// ----------------------------------------------------------------------------
// Keys enter on the s_ side one word per cycle; the word with s_tlast ends
// the list. Each key is inserted into a chain of DEPTH cells that keeps the
// list sorted as it arrives, and the smallest key is on m_tdata in the cycle
// after the last key is taken. The sorted keys then leave one word per cycle
// while m_tready is high, the chain shifting one cell toward the output per
// word. No key is taken while a list is being sent. Keys past DEPTH are
// discarded and every word of that list carries m_tuser = 1.
// ----------------------------------------------------------------------------
module bottom_up_merge_sorter #(
	parameter int DEPTH    = 64,
	parameter int KEY_BITS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [15:0] s_tdata,   // [15:0] key_in
	input  wire         s_tlast,   // last_in
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata,   // [15:0] key_out
	output logic        m_tlast,   // last_out
	output logic        m_tuser    // dropped
);

	localparam int SKW = (KEY_BITS < bums_pkg::KEY_W) ? KEY_BITS : bums_pkg::KEY_W;
	localparam int CW  = $clog2(DEPTH + 1);

	typedef enum logic {ST_LOAD, ST_DRAIN} state_t;

	state_t              state_q;
	logic [CW-1:0]       cnt_q;
	logic                ovf_q;

	logic                s_acc;
	logic                m_acc;
	logic                room;
	bums_pkg::bums_ctl_t ctl;
	logic [SKW-1:0]      new_key;

	logic [DEPTH-1:0]    valid_w;
	logic [DEPTH-1:0]    keep_w;
	logic [SKW-1:0]      key_w [DEPTH];

	assign s_tready = (state_q == ST_LOAD);
	assign m_tvalid = (state_q == ST_DRAIN);
	assign s_acc    = s_tvalid && s_tready;
	assign m_acc    = m_tvalid && m_tready;
	assign room     = (cnt_q < CW'(DEPTH));
	assign new_key  = s_tdata[SKW-1:0];

	assign ctl.ins   = s_acc && room;
	assign ctl.shift = m_acc;

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic           lk;
			logic [SKW-1:0] lkey;
			logic           lv;
			logic [SKW-1:0] rkey;
			logic           rv;

			if (gi == 0) begin : g_head
				assign lk   = 1'b1;
				assign lkey = '0;
				assign lv   = 1'b0;
			end else begin : g_body
				assign lk   = keep_w[gi-1];
				assign lkey = key_w[gi-1];
				assign lv   = valid_w[gi-1];
			end

			if (gi == DEPTH - 1) begin : g_tail
				assign rkey = '0;
				assign rv   = 1'b0;
			end else begin : g_mid
				assign rkey = key_w[gi+1];
				assign rv   = valid_w[gi+1];
			end

			bums_cell #(.KW(SKW)) u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctl         (ctl),
				.new_key     (new_key),
				.left_keep   (lk),
				.left_key    (lkey),
				.left_valid  (lv),
				.right_key   (rkey),
				.right_valid (rv),
				.keep        (keep_w[gi]),
				.key         (key_w[gi]),
				.valid       (valid_w[gi])
			);
		end
	endgenerate

	// head cell is the output word
	always_comb begin
		m_tdata = '0;
		m_tdata[SKW-1:0] = key_w[0];
	end
	assign m_tlast = (cnt_q == CW'(1));
	assign m_tuser = ovf_q;

	// cnt_q counts stored keys while loading and keys left while sending
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (s_acc) begin
						if (room) begin
							cnt_q <= cnt_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (s_tlast) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (m_acc) begin
						cnt_q <= cnt_q - CW'(1);
						if (cnt_q == CW'(1)) begin
							state_q <= ST_LOAD;
							ovf_q   <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// chain occupancy always matches the key counter
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_w) == int'(cnt_q))
		else $error("cell chain occupancy differs from key count");

	// while sending, the head cell holds a key
	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> valid_w[0])
		else $error("sending with empty head cell");

	// words of one list leave in ascending order
	a_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		(m_acc && !m_tlast) |=> (m_tdata >= $past(m_tdata)))
		else $error("sorted output not ascending");

endmodule
`default_nettype wire
